>>> rtl/core/oks_pkg.sv
// Package for the ordered key set table.
// Holds the request codes, field widths and the result record.
// It has no dependencies and is used by oks_ctrl and ordered_key_set_table.
`timescale 1ns / 1ps
`default_nettype none

package oks_pkg;

	// Widths of the fields on the ports.
	localparam int KEY_W   = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	// Request codes.
	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_ERASE    = 2'd1;
	localparam logic [1:0] REQ_CONTAINS = 2'd2;
	localparam logic [1:0] REQ_GET      = 2'd3;

	// One result transaction.
	typedef struct packed {
		logic               success;
		logic               set_full;
		logic [KEY_W-1:0]   read_key;
		logic [COUNT_W-1:0] element_count;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/ordered_key_set_table.sv
// A bounded set of distinct keys kept newest first, serving insert, erase, contains and
// get-by-position requests with one result transaction each. Requests are taken one at a
// time: in_stall is high while a request is in work. Insert, erase and contains scan the
// stored keys oldest first through a key memory with one write port and one registered read
// port, one entry per cycle. A miss scans every stored key before its result enters the
// output register. A hit at position p ends the scan early. An erase that hits then moves
// the p newer keys down one entry before its result is built. A get reads one key, or none
// when the position is out of range. The block returns to idle after each request before
// the next one is taken, and a result that cannot enter the output register keeps the
// block busy. The next request may be taken while a result still waits in the output
// register.
// Uses oks_pkg, oks_store and oks_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_set_table #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] key,
	input  wire logic [3:0]  position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             success,
	output logic             set_full,
	output logic [31:0]      read_key,
	output logic [4:0]       element_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                res_valid;
	logic                res_take;
	oks_pkg::result_t    res;
	oks_pkg::result_t    out_q;
	logic                out_valid_q;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [KEY_BITS-1:0] mem_wdata;
	logic                mem_re;
	logic [IW-1:0]       mem_raddr;
	logic [KEY_BITS-1:0] mem_rdata;

	oks_store #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_BITS),
		.AW    (IW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	oks_ctrl #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.CW       (CW),
		.IW       (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.busy      (in_stall),
		.req_type  (req_type),
		.key       (key),
		.position  (position),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_q     (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// The output register takes a result when it is empty or being drained.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; held while the transaction is stalled.
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign success       = out_q.success;
	assign set_full      = out_q.set_full;
	assign read_key      = out_q.read_key;
	assign element_count = out_q.element_count;

endmodule

`default_nettype wire

>>> rtl/core/oks_store.sv
// Key memory for the ordered key set table.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oks_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/oks_ctrl.sv
// Sequencer and compare unit of the ordered key set table.
// Scans and compacts the key memory one entry per cycle; uses oks_pkg.
// Keys are held oldest first in memory, so the newest key sits at address count-1.
`timescale 1ns / 1ps
`default_nettype none

module oks_ctrl #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32,
	parameter int CW       = 5,
	parameter int IW       = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      busy,
	input  wire logic [1:0]           req_type,
	input  wire logic [oks_pkg::KEY_W-1:0] key,
	input  wire logic [oks_pkg::POS_W-1:0] position,
	output logic                      res_valid,
	input  wire logic                 res_take,
	output oks_pkg::result_t          res_q,
	output logic                      mem_we,
	output logic [IW-1:0]             mem_waddr,
	output logic [KEY_BITS-1:0]       mem_wdata,
	output logic                      mem_re,
	output logic [IW-1:0]             mem_raddr,
	input  wire logic [KEY_BITS-1:0]  mem_rdata
);

	localparam int KB = (KEY_BITS < oks_pkg::KEY_W) ? KEY_BITS : oks_pkg::KEY_W;
	localparam int PW = (CW > oks_pkg::POS_W) ? CW : oks_pkg::POS_W;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_GET   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic                rd_vld_s1;
	logic [CW-1:0]       rd_idx_s1;

	logic                key_hit;
	logic                scan_rd;
	logic                scan_end;
	logic                get_ok;
	logic [PW-1:0]       get_addr;
	logic [CW-1:0]       shift_dst;
	logic [KEY_BITS-1:0] key_m;
	logic                ins_write;

	// Masked key and the compare unit shared by every scan.
	assign key_m     = KEY_BITS'(key[KB-1:0]);
	assign key_hit   = rd_vld_s1 && (mem_rdata == key_q);
	assign scan_rd   = idx_q < cnt_q;
	assign scan_end  = !rd_vld_s1 && !scan_rd;
	assign shift_dst = rd_idx_s1 - CW'(1);

	// Position check and address for a get (newest key at the top address).
	assign get_ok   = PW'(position) < PW'(cnt_q);
	assign get_addr = PW'(cnt_q) - PW'(position) - PW'(1);

	assign ins_write = (state_q == S_SCAN) && !key_hit && scan_end &&
		(req_q == oks_pkg::REQ_INSERT) && (cnt_q != CAP);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);

	// Memory port selection.
	always_comb begin
		mem_we    = ins_write || ((state_q == S_SHIFT) && rd_vld_s1);
		mem_waddr = (state_q == S_SCAN) ? cnt_q[IW-1:0] : shift_dst[IW-1:0];
		mem_wdata = (state_q == S_SCAN) ? key_q : mem_rdata;
		if (state_q == S_IDLE) begin
			mem_re    = in_valid && (req_type == oks_pkg::REQ_GET) && get_ok;
			mem_raddr = get_addr[IW-1:0];
		end else begin
			mem_re    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && scan_rd;
			mem_raddr = idx_q[IW-1:0];
		end
	end

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
						if (req_type != oks_pkg::REQ_GET) begin
							state_q <= S_SCAN;
						end else if (get_ok) begin
							state_q <= S_GET;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (key_hit) begin
						if (req_q == oks_pkg::REQ_ERASE) begin
							idx_q     <= rd_idx_s1 + CW'(1);
							rd_vld_s1 <= 1'b0;
							state_q   <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
					end else if (scan_end) begin
						if (ins_write) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= S_DONE;
					end else begin
						rd_vld_s1 <= scan_rd;
						if (scan_rd) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (scan_end) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						rd_vld_s1 <= scan_rd;
						if (scan_rd) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_GET: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request registers and the scan read index.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= req_type;
			key_q <= key_m;
		end
		if (state_q == S_SCAN || state_q == S_SHIFT) begin
			rd_idx_s1 <= idx_q;
		end
	end

	// Result record, built as the request completes.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q <= '{success: 1'b0, set_full: 1'b0, read_key: '0,
					element_count: oks_pkg::COUNT_W'(cnt_q)};
			end
			S_SCAN: begin
				if (key_hit) begin
					res_q.success <= (req_q == oks_pkg::REQ_CONTAINS);
				end else if (scan_end) begin
					if (ins_write) begin
						res_q.success       <= 1'b1;
						res_q.element_count <= oks_pkg::COUNT_W'(cnt_q + CW'(1));
					end else if (req_q == oks_pkg::REQ_INSERT) begin
						res_q.set_full <= 1'b1;
					end
				end
			end
			S_SHIFT: begin
				if (scan_end) begin
					res_q.success       <= 1'b1;
					res_q.element_count <= oks_pkg::COUNT_W'(cnt_q - CW'(1));
				end
			end
			S_GET: begin
				res_q.success  <= 1'b1;
				res_q.read_key <= oks_pkg::KEY_W'(mem_rdata[KB-1:0]);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// The count never exceeds the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("entry count above capacity");

	// Writes land only inside the occupied region or at its first free entry.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= cnt_q))
		else $error("key memory write outside the occupied region");

	// The count changes only when a scan or a compaction finishes.
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN && state_q != S_SHIFT) |=> $stable(cnt_q))
		else $error("entry count changed outside a scan or compaction");

	// A finished result waits unchanged until the output takes it.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_take) |=> (res_valid && $stable(res_q)))
		else $error("pending result changed before it was taken");

endmodule

`default_nettype wire
